FILE: hw/rtl/cidlp_pkg.sv
// Shared types and constants for the card ID list parser.
// No dependencies; the front end, queue, back end, top level and testbench import this package.
package cidlp_pkg;

  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned QueuePtrW    = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW    = $clog2(QueueDepth + 1);

  localparam logic [7:0]  HexDigitsMax = 8'd8;
  localparam logic [7:0]  CountSat     = 8'd255;
  localparam logic [31:0] DecLimitDiv  = 32'd429496729;
  localparam logic [3:0]  DecLimitMod  = 4'd5;
  localparam logic [15:0] CapacityRst  = 16'hFFFF;

  // Byte classes produced by the front end.
  typedef enum logic [3:0] {
    CLS_EOF     = 4'd0,
    CLS_APOS    = 4'd1,
    CLS_NEWLINE = 4'd2,
    CLS_SEMI    = 4'd3,
    CLS_SPACE   = 4'd4,
    CLS_SEP     = 4'd5,
    CLS_DEC     = 4'd6,
    CLS_HEX     = 4'd7,
    CLS_OTHER   = 4'd8
  } byte_class_e;

  typedef enum logic [2:0] {
    STAGE_START   = 3'b001,
    STAGE_BODY    = 3'b010,
    STAGE_COMMENT = 3'b100
  } line_stage_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_TOO_MANY  = 2'd2
  } status_e;

  // One classified byte as it travels through the queue.
  typedef struct packed {
    byte_class_e cls;
    logic [3:0]  digit;
  } token_t;

endpackage

FILE: hw/rtl/cidlp_byte_if.sv
// Input channel of the card ID list parser: file bytes and end of file.
// No dependencies.
interface cidlp_byte_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

FILE: hw/rtl/cidlp_card_if.sv
// Result channel of the card ID list parser: one result per input transfer.
// No dependencies.
interface cidlp_card_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        card_valid;
  logic [31:0] card_number;
  logic [15:0] card_index;

  modport source (output valid, output status, output card_valid, output card_number,
                  output card_index, input ready);
  modport sink   (input valid, input status, input card_valid, input card_number,
                  input card_index, output ready);
endinterface

FILE: hw/rtl/cidlp_front.sv
// Front end: classifies each incoming byte and extracts its digit value.
// Depends on cidlp_pkg.
module cidlp_front import cidlp_pkg::*; (
  input  logic       kind_i,
  input  logic [7:0] data_byte_i,
  output token_t     token_o
);

  always_comb begin
    token_o.digit = data_byte_i[3:0];
    token_o.cls   = CLS_OTHER;
    if (kind_i) begin
      token_o.cls = CLS_EOF;
    end else if (data_byte_i >= 8'h30 && data_byte_i <= 8'h39) begin
      token_o.cls = CLS_DEC;
    end else if ((data_byte_i >= 8'h61 && data_byte_i <= 8'h66) ||
                 (data_byte_i >= 8'h41 && data_byte_i <= 8'h46)) begin
      // Low nibble of a..f and A..F is 1..6, so adding nine gives 10..15.
      token_o.cls   = CLS_HEX;
      token_o.digit = data_byte_i[3:0] + 4'd9;
    end else if (data_byte_i == 8'h0A) begin
      token_o.cls = CLS_NEWLINE;
    end else if (data_byte_i == 8'h20 || (data_byte_i >= 8'h09 && data_byte_i <= 8'h0D)) begin
      token_o.cls = CLS_SPACE;
    end else if (data_byte_i == 8'h27) begin
      token_o.cls = CLS_APOS;
    end else if (data_byte_i == 8'h3B) begin
      token_o.cls = CLS_SEMI;
    end else if (data_byte_i == 8'h2D || data_byte_i == 8'h5F || data_byte_i == 8'h2E) begin
      token_o.cls = CLS_SEP;
    end
  end

endmodule

FILE: hw/rtl/cidlp_queue.sv
// Short token queue between the front end and the back end.
// Depends on cidlp_pkg.
module cidlp_queue import cidlp_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  token_t push_data_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   empty_o,
  output token_t pop_data_o
);

  token_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0]   count_q, count_d;

  localparam logic [QueuePtrW-1:0] LastPtr = QueuePtrW'(QueueDepth - 1);
  localparam logic [QueueCntW-1:0] FullCnt = QueueCntW'(QueueDepth);

  assign full_o     = (count_q == FullCnt);
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: hw/rtl/cidlp_back.sv
// Back end: line state machine, number accumulation and the result register.
// Depends on cidlp_pkg.
module cidlp_back import cidlp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] capacity_i,
  input  logic        tok_valid_i,
  input  token_t      tok_i,
  output logic        tok_pop_o,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic [1:0]  status_o,
  output logic        card_valid_o,
  output logic [31:0] card_number_o,
  output logic [15:0] card_index_o
);

  line_stage_e stage_q, stage_d;
  logic        dec_q, dec_d;
  logic [31:0] acc_q, acc_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [15:0] stored_q, stored_d;

  logic        out_valid_q;
  status_e     status_q, status_d;
  logic        card_valid_q, card_valid_d;
  logic [31:0] number_q, number_d;
  logic [15:0] index_q, index_d;

  logic        finish;
  logic [31:0] acc_times10;
  logic        dec_fits;

  // The result register frees up in the same cycle it is taken.
  assign tok_pop_o = tok_valid_i && (!out_valid_q || res_ready_i);

  assign acc_times10 = {acc_q[28:0], 3'b000} + {acc_q[30:0], 1'b0} + {28'd0, tok_i.digit};
  assign dec_fits    = (acc_q < DecLimitDiv) ||
                       (acc_q == DecLimitDiv && tok_i.digit <= DecLimitMod);

  always_comb begin
    stage_d      = stage_q;
    dec_d        = dec_q;
    acc_d        = acc_q;
    cnt_d        = cnt_q;
    stored_d     = stored_q;
    status_d     = ST_OK;
    card_valid_d = 1'b0;
    number_d     = '0;
    index_d      = '0;
    finish       = 1'b0;

    if (tok_i.cls == CLS_EOF) begin
      finish = 1'b1;
    end else if (stage_q == STAGE_COMMENT) begin
      finish = (tok_i.cls == CLS_NEWLINE);
    end else if (stage_q == STAGE_START && tok_i.cls == CLS_APOS) begin
      dec_d = 1'b1;
    end else begin
      // Any non-whitespace byte at line start opens the body, even a malformed one.
      if (stage_q == STAGE_START && tok_i.cls != CLS_SPACE && tok_i.cls != CLS_NEWLINE) begin
        stage_d = STAGE_BODY;
      end
      unique case (tok_i.cls)
        CLS_NEWLINE: finish = 1'b1;
        CLS_SEMI:    stage_d = STAGE_COMMENT;
        CLS_DEC, CLS_HEX: begin
          if (!dec_q) begin
            if (cnt_q >= HexDigitsMax) begin
              status_d = ST_MALFORMED;
            end else begin
              acc_d = {acc_q[27:0], tok_i.digit};
              cnt_d = cnt_q + 8'd1;
            end
          end else if (tok_i.cls == CLS_DEC && dec_fits) begin
            acc_d = acc_times10;
            if (cnt_q < CountSat) begin
              cnt_d = cnt_q + 8'd1;
            end
          end else begin
            status_d = ST_MALFORMED;
          end
        end
        CLS_SPACE, CLS_SEP: ;
        default: status_d = ST_MALFORMED;
      endcase
    end

    if (finish) begin
      if (cnt_q != '0) begin
        if (stored_q < capacity_i) begin
          card_valid_d = 1'b1;
          number_d     = acc_q;
          index_d      = stored_q;
          stored_d     = stored_q + 16'd1;
        end else begin
          status_d = ST_TOO_MANY;
        end
      end
      stage_d = STAGE_START;
      dec_d   = 1'b0;
      acc_d   = '0;
      cnt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q     <= STAGE_START;
      dec_q       <= 1'b0;
      acc_q       <= '0;
      cnt_q       <= '0;
      stored_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (tok_pop_o) begin
        stage_q  <= stage_d;
        dec_q    <= dec_d;
        acc_q    <= acc_d;
        cnt_q    <= cnt_d;
        stored_q <= stored_d;
      end
      if (tok_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_pop_o) begin
      status_q     <= status_d;
      card_valid_q <= card_valid_d;
      number_q     <= number_d;
      index_q      <= index_d;
    end
  end

  assign res_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign card_valid_o  = card_valid_q;
  assign card_number_o = number_q;
  assign card_index_o  = index_q;

  a_card_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_pop_o && card_valid_d |-> status_d == ST_OK)
    else $error("card emitted with a non-success status");

  a_no_card_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_pop_o && !card_valid_d |-> number_d == '0 && index_d == '0)
    else $error("card fields not cleared on a result without a card");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_pop_o && card_valid_d |=> stored_q == $past(index_d) + 16'd1)
    else $error("stored card count did not follow the emitted index");

  a_line_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_pop_o && finish |=> stage_q == STAGE_START && cnt_q == '0 && !dec_q)
    else $error("line state not cleared after a line end");

endmodule

FILE: hw/rtl/card_id_list_parser.sv
// Top level of the card ID list parser: front end, token queue, back end.
// Depends on cidlp_pkg, cidlp_byte_if, cidlp_card_if, cidlp_front, cidlp_queue, cidlp_back.
//
//   Port          Direction  Role
//   byte_i        sink       file bytes (kind 0) and end of file (kind 1)
//   result_o      source     one status/card result per input transfer
//   cfg_we_i      input      writes cfg_wdata_i into the card limit register
//
// One byte per cycle sustained while results are taken; the classified byte enters
// the queue at the transfer edge, and the line update then loads the result register
// once that register is free.
// While a result waits to be taken, the two-entry queue holds up to two more transfers.
// Reset clears the line state, the stored card count and the queue; the card limit
// returns to 65535.
module card_id_list_parser import cidlp_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  cidlp_byte_if.sink    byte_i,
  cidlp_card_if.source  result_o,
  input  logic          cfg_we_i,
  input  logic [15:0]   cfg_wdata_i
);

  logic [15:0] capacity_q;
  token_t      front_tok;
  token_t      queue_tok;
  logic        queue_full;
  logic        queue_empty;
  logic        queue_pop;
  logic        push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CapacityRst;
    end else if (cfg_we_i) begin
      capacity_q <= cfg_wdata_i;
    end
  end

  assign byte_i.ready = !queue_full;
  assign push         = byte_i.valid && !queue_full;

  cidlp_front u_front (
    .kind_i      (byte_i.kind),
    .data_byte_i (byte_i.data_byte),
    .token_o     (front_tok)
  );

  cidlp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_tok),
    .full_o      (queue_full),
    .pop_i       (queue_pop),
    .empty_o     (queue_empty),
    .pop_data_o  (queue_tok)
  );

  cidlp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .capacity_i    (capacity_q),
    .tok_valid_i   (!queue_empty),
    .tok_i         (queue_tok),
    .tok_pop_o     (queue_pop),
    .res_valid_o   (result_o.valid),
    .res_ready_i   (result_o.ready),
    .status_o      (result_o.status),
    .card_valid_o  (result_o.card_valid),
    .card_number_o (result_o.card_number),
    .card_index_o  (result_o.card_index)
  );

endmodule

FILE: test/tb.sv
// Testbench for card_id_list_parser: random and directed text lines through the byte channel.
// Depends on cidlp_pkg, cidlp_byte_if, cidlp_card_if and the parser RTL; results are checked
// against a line parser kept inside this file.
`timescale 1ns / 100ps

module tb;
  import cidlp_pkg::*;

  localparam logic [7:0] ChApos  = 8'h27;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChUnder = 8'h5F;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChSpace = 8'h20;

  typedef struct {
    logic       kind;
    logic [7:0] data;
    bit         hold;
  } byte_item_t;

  typedef struct {
    status_e     status;
    logic        card_valid;
    logic [31:0] number;
    logic [15:0] index;
  } card_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;

  cidlp_byte_if byte_bus ();
  cidlp_card_if card_bus ();

  card_id_list_parser dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_i     (byte_bus),
    .result_o   (card_bus),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Parser state as the block should hold it.
  line_stage_e line_stage;
  logic        in_decimal;
  logic [31:0] acc_num;
  logic [7:0]  digit_cnt;
  logic [15:0] cards_seen;
  logic [15:0] card_limit;

  byte_item_t byte_pend_q[$];
  card_res_t  card_exp_q[$];

  int  errors;
  int  items_made;
  bit  hold_next;
  int  send_pct;
  int  recv_pct;
  int  send_calm;
  int  recv_calm;
  byte unsigned ws_set[5] = '{8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D};
  string hex_set = "0123456789abcdefABCDEF";
  string sep_set = " \t-_.";

  function automatic bit is_space(logic [7:0] b);
    return b == ChSpace || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  // Closes the current line and emits its card, if it had digits and the card limit is not reached.
  function automatic card_res_t close_line();
    card_res_t r;
    r = '{ST_OK, 1'b0, 32'd0, 16'd0};
    if (digit_cnt != 8'd0) begin
      if (cards_seen < card_limit) begin
        r.card_valid = 1'b1;
        r.number = acc_num;
        r.index = cards_seen;
        cards_seen = cards_seen + 16'd1;
      end else begin
        r.status = ST_TOO_MANY;
      end
    end
    line_stage = STAGE_START;
    in_decimal = 1'b0;
    acc_num = 32'd0;
    digit_cnt = 8'd0;
    return r;
  endfunction

  function automatic card_res_t parse_byte(logic kind, logic [7:0] b);
    card_res_t r;
    logic [4:0] hv;
    logic [3:0] d;
    r = '{ST_OK, 1'b0, 32'd0, 16'd0};
    hv = 5'd16;
    d = b[3:0];
    if (b >= "0" && b <= "9") hv = {1'b0, b[3:0]};
    else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F")) hv = {1'b0, b[3:0]} + 5'd9;
    // A newline closes the line in every stage, the comment included.
    if (kind || b == ChLf) begin
      r = close_line();
    end else if (line_stage == STAGE_START && b == ChApos) begin
      in_decimal = 1'b1;
    end else if (line_stage != STAGE_COMMENT) begin
      if (line_stage == STAGE_START && !is_space(b)) line_stage = STAGE_BODY;
      if (b == ChSemi) begin
        line_stage = STAGE_COMMENT;
      end else if (!in_decimal && hv < 5'd16) begin
        if (digit_cnt >= HexDigitsMax) begin
          r.status = ST_MALFORMED;
        end else begin
          acc_num = {acc_num[27:0], hv[3:0]};
          digit_cnt = digit_cnt + 8'd1;
        end
      end else if (in_decimal && b >= "0" && b <= "9") begin
        if (acc_num < DecLimitDiv || (d <= DecLimitMod && acc_num <= DecLimitDiv)) begin
          acc_num = acc_num * 32'd10 + {28'd0, d};
          if (digit_cnt < CountSat) digit_cnt = digit_cnt + 8'd1;
        end else begin
          r.status = ST_MALFORMED;
        end
      end else if (!(is_space(b) || b == ChDash || b == ChUnder || b == ChDot)) begin
        r.status = ST_MALFORMED;
      end
    end
    return r;
  endfunction

  // Random stall with occasional calm stretches in which nothing stalls.
  function automatic bit stall_now(input int pct, inout int calm);
    bit s;
    s = 1'b0;
    if (pct != 0) begin
      if (calm > 0) calm--;
      else if ($urandom_range(99) < 3) calm = $urandom_range(40, 10);
      else s = ($urandom_range(99) < pct);
    end
    return s;
  endfunction

  function automatic bit roll(int pct);
    return $urandom_range(99) < pct;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("tb: done, errors");
    $finish;
  end

  // Driver: presents pending bytes and predicts each transfer as it is accepted.
  always @(posedge clk_i or negedge rst_ni) begin : drive_bytes
    byte_item_t it;
    if (!rst_ni) begin
      byte_bus.valid <= 1'b0;
      byte_bus.kind <= 1'b0;
      byte_bus.data_byte <= 8'h00;
    end else begin
      if (byte_bus.valid && byte_bus.ready)
        card_exp_q.push_back(parse_byte(byte_bus.kind, byte_bus.data_byte));
      if (!byte_bus.valid || byte_bus.ready) begin
        if (byte_pend_q.size() != 0 && !(byte_pend_q[0].hold && card_exp_q.size() != 0) &&
            !stall_now(send_pct, send_calm)) begin
          it = byte_pend_q.pop_front();
          byte_bus.valid <= 1'b1;
          byte_bus.kind <= it.kind;
          byte_bus.data_byte <= it.data;
        end else begin
          byte_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : check_cards
    card_res_t want;
    if (!rst_ni) begin
      card_bus.ready <= 1'b0;
    end else begin
      if (card_bus.valid && card_bus.ready) begin
        if (card_exp_q.size() == 0) begin
          $error("result without a pending input transfer");
          errors++;
        end else begin
          want = card_exp_q.pop_front();
          if (card_bus.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, card_bus.status);
            errors++;
          end
          if (card_bus.card_valid !== want.card_valid) begin
            $error("card_valid: expected %0d, actual %0d", want.card_valid, card_bus.card_valid);
            errors++;
          end
          if (card_bus.card_number !== want.number) begin
            $error("card_number: expected %h, actual %h", want.number, card_bus.card_number);
            errors++;
          end
          if (card_bus.card_index !== want.index) begin
            $error("card_index: expected %0d, actual %0d", want.index, card_bus.card_index);
            errors++;
          end
        end
      end
      card_bus.ready <= !stall_now(recv_pct, recv_calm);
    end
  end

  task automatic push_item(input logic kind, input logic [7:0] data);
    byte_pend_q.push_back('{kind, data, hold_next});
    hold_next = 1'b0;
    items_made++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_item(1'b0, s[i]);
  endtask

  // Digits may be split by separators, and now and then by a stray byte.
  task automatic push_digit(input logic [7:0] b);
    if (roll(12)) push_item(1'b0, sep_set[$urandom_range(4)]);
    if (roll(3)) push_item(1'b0, roll(50) ? ChApos : 8'($urandom_range(255)));
    push_item(1'b0, b);
  endtask

  task automatic push_line();
    int n;
    bit all_f;
    string lim;
    lim = "429496729";
    n = $urandom_range(2);
    repeat (n) push_item(1'b0, ws_set[$urandom_range(4)]);
    if (roll(40)) begin
      repeat ($urandom_range(3, 1)) push_item(1'b0, ChApos);
      if (roll(30)) begin
        // Values around the 32-bit limit, past it when the tenth digit exceeds 5 or an extra digit follows.
        for (int i = 0; i < 9; i++) push_digit(lim[i]);
        push_digit(8'("0" + $urandom_range(9)));
        if (roll(30)) push_digit(8'("0" + $urandom_range(9)));
      end else begin
        repeat ($urandom_range(10, 1)) push_digit(8'("0" + $urandom_range(9)));
      end
    end else begin
      n = roll(10) ? 9 : $urandom_range(8, 1);
      all_f = roll(20);
      repeat (n) push_digit(all_f ? (roll(50) ? "f" : "F") : hex_set[$urandom_range(21)]);
    end
    if (roll(20)) begin
      push_item(1'b0, ChSemi);
      repeat ($urandom_range(4)) push_item(1'b0, 8'($urandom_range(255)) | 8'h80);
      if (roll(50)) push_text("x'g;");
    end
    if (roll(90)) push_item(1'b0, ChLf);
    else push_item(1'b1, 8'($urandom_range(255)));
  endtask

  task automatic run_random(input int n);
    int stop;
    stop = items_made + n;
    while (items_made < stop) begin
      if (roll(85)) begin
        push_line();
      end else begin
        repeat ($urandom_range(6, 1)) push_item(roll(10), 8'($urandom_range(255)));
      end
    end
  endtask

  // Waits until every byte is sent and every result is back, plus the pipeline depth.
  task automatic wait_drained();
    int n;
    n = 0;
    while (n < 50000 && (byte_pend_q.size() != 0 || byte_bus.valid || card_exp_q.size() != 0))
    begin
      @(negedge clk_i);
      n++;
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [15:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    card_limit = v;
    @(negedge clk_i);
  endtask

  initial begin
    errors = 0;
    items_made = 0;
    hold_next = 1'b0;
    send_pct = 0;
    recv_pct = 0;
    send_calm = 0;
    recv_calm = 0;
    line_stage = STAGE_START;
    in_decimal = 1'b0;
    acc_num = 32'd0;
    digit_cnt = 8'd0;
    cards_seen = 16'd0;
    card_limit = CapacityRst;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 16'h0000;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Hex with separators and a comment holding an otherwise malformed byte.
    push_text("A-f;x\n");
    // Apostrophes after leading space switch to decimal; a later one is malformed.
    push_text(" ''9'\n");
    // A malformed first byte moves the line to its body, so the apostrophe fails too.
    push_text("g'");
    push_item(1'b1, 8'hFF);
    // End of file flushes a pending card.
    push_text("0.");
    push_item(1'b1, 8'h00);
    push_item(1'b0, 8'hFF);
    push_item(1'b0, 8'h00);
    push_text("\n");
    wait_drained();

    send_pct = 49;
    run_random(250);
    wait_drained();

    write_capacity(16'd0);
    send_pct = 0;
    recv_pct = 49;
    run_random(150);
    wait_drained();

    write_capacity(cards_seen + 16'd3);
    send_pct = 37;
    recv_pct = 37;
    run_random(125);
    hold_next = 1'b1;
    run_random(125);
    wait_drained();

    write_capacity(16'hFFFF);
    send_pct = 0;
    recv_pct = 0;
    run_random(250);
    wait_drained();
    repeat (10) @(negedge clk_i);

    if (card_exp_q.size() != 0) begin
      $error("%0d results never arrived", card_exp_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
